### rtl/bbum_pkg.sv
// Package for the box blur unsharp mask block.
// Holds field widths, register indexes, reset values and operation codes.
// No dependencies.
`default_nettype none

package bbum_pkg;

   localparam int PIXEL_BITS     = 8;
   localparam int WIDTH_BITS     = 12;
   localparam int HEIGHT_BITS    = 13;
   localparam int RADIUS_BITS    = 4;
   localparam int AMOUNT_BITS    = 12;
   localparam int THRESH_BITS    = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 13;
   localparam int CNT_BITS       = 25;

   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_RADIUS = 8;

   localparam logic [WIDTH_BITS-1:0]  RST_WIDTH  = WIDTH_BITS'(640);
   localparam logic [HEIGHT_BITS-1:0] RST_HEIGHT = HEIGHT_BITS'(480);
   localparam logic [RADIUS_BITS-1:0] RST_RADIUS = RADIUS_BITS'(1);
   localparam logic [AMOUNT_BITS-1:0] RST_AMOUNT = AMOUNT_BITS'(256);
   localparam logic [THRESH_BITS-1:0] RST_THRESH = THRESH_BITS'(0);

   localparam logic [PIXEL_BITS-1:0]  PIX_MAX = PIXEL_BITS'(255);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH     = 3'd0,
      CSR_FRAME_HEIGHT    = 3'd1,
      CSR_BLUR_RADIUS     = 3'd2,
      CSR_SHARPEN_AMOUNT  = 3'd3,
      CSR_NOISE_THRESHOLD = 3'd4
   } csr_index_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

endpackage

`default_nettype wire

### rtl/bbum_req_if.sv
// Input channel of the box blur unsharp mask block: valid/ready plus payload.
// Depends on bbum_pkg.
`default_nettype none

interface bbum_req_if;
   import bbum_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  operation;
   logic [PIXEL_BITS-1:0] pixel_in;

   modport source (output valid, output operation, output pixel_in, input ready);
   modport sink   (input valid, input operation, input pixel_in, output ready);
endinterface

`default_nettype wire

### rtl/bbum_rsp_if.sv
// Result channel of the box blur unsharp mask block: valid/ready plus payload.
// Depends on bbum_pkg.
`default_nettype none

interface bbum_rsp_if;
   import bbum_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_out;
   logic                  frame_last;

   modport source (output valid, output pixel_out, output frame_last, input ready);
   modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

`default_nettype wire

### rtl/bbum_line_store.sv
// Ring of pixel rows: one write port and one read port with registered data.
// Depends on bbum_pkg.
`default_nettype none

module bbum_line_store #(
   parameter int DEPTH = 18 * 2048,
   parameter int AB    = $clog2(18 * 2048)
) (
   input  wire                             clock,
   input  wire                             wr_en,
   input  wire [AB-1:0]                    wr_addr,
   input  wire [bbum_pkg::PIXEL_BITS-1:0]  wr_data,
   input  wire                             rd_en,
   input  wire [AB-1:0]                    rd_addr,
   output logic [bbum_pkg::PIXEL_BITS-1:0] rd_data_ff
);
   import bbum_pkg::*;

   logic [PIXEL_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/bbum_divider.sv
// Divider by a per-frame constant: multiplies by a scaled reciprocal and registers the quotient.
// Depends on bbum_pkg (house import only).
`default_nettype none

module bbum_divider #(
   parameter int NUM_BITS = 17,
   parameter int REC_BITS = 27,
   parameter int SHIFT    = 26
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   input  wire [NUM_BITS-1:0]  num,
   input  wire [REC_BITS-1:0]  recip,
   output logic                done_ff,
   output logic [NUM_BITS-1:0] quo_ff
);
   import bbum_pkg::*;

   localparam int PB = NUM_BITS + REC_BITS;

   logic [PB-1:0] prod;

   // The reciprocal is rounded up, and SHIFT leaves enough headroom that the
   // floor of the scaled product equals the floor of the true quotient.
   assign prod = PB'(num) * PB'(recip);

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= prod[SHIFT +: NUM_BITS];
      end
   end

endmodule

`default_nettype wire

### rtl/box_blur_unsharp_mask_top.sv
// Top level of the box blur unsharp mask block.
// Depends on bbum_pkg, bbum_req_if, bbum_rsp_if, bbum_line_store and bbum_divider.
`default_nettype none

// Sharpens an 8-bit greyscale frame that arrives in raster order, one pixel per
// input transaction. Each pixel is compared with the rounded mean of the square
// box of side 2*R+1 around it, borders mirrored without repeating the edge
// pixel. The difference, zeroed below the noise threshold, is scaled by the
// Q4.8 amount and added back, rounded and clamped to 0..255. Results come out
// R rows plus R pixels behind the input; drain transactions flush the tail,
// and frame_last marks the final pixel. The five registers are captured when
// the first pixel of a frame arrives, so writes take effect on the next frame.
// Incoming pixels go into a ring of 2*MAX_RADIUS+2 rows held in one memory.
// Items are handled one at a time. A drain that produces no result is dropped;
// a pixel is written to the ring, after a setup step when it opens a frame.
// One that produces a result walks the (2R+1)^2 window through the single
// memory read port, one pixel per cycle, and forms the mean with one multiply
// by the reciprocal of the window size. Its result is registered after the
// centre read, the divider, the gain multiply and the rounding step, and the
// next transaction is taken once the result has been accepted. No new
// transaction is taken while a result waits on the output.

module box_blur_unsharp_mask_top #(
   parameter int MAX_WIDTH  = bbum_pkg::DEF_MAX_WIDTH,
   parameter int MAX_RADIUS = bbum_pkg::DEF_MAX_RADIUS
) (
   input  wire                                clock,
   input  wire                                reset,
   bbum_req_if.sink                           req_chan,
   bbum_rsp_if.source                         rsp_chan,
   input  wire                                csr_wr_en,
   input  wire [bbum_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire [bbum_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);
   import bbum_pkg::*;

   localparam int RING  = 2 * MAX_RADIUS + 2;
   localparam int RGB   = $clog2(RING);
   localparam int CB    = $clog2(MAX_WIDTH);
   localparam int RB    = $clog2(MAX_RADIUS + 1);
   localparam int DEPTH = RING * MAX_WIDTH;
   localparam int AB    = $clog2(DEPTH);
   localparam int NMAX  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
   localparam int SB    = $clog2(NMAX * 256);
   localparam int KB    = 2 * $clog2(NMAX) + 8;
   localparam int RCB   = KB + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_LAG, S_PIX, S_WIN, S_CTR, S_RDW, S_DSET, S_DIV, S_MUL, S_RND
   } state_type;

   state_type state_ff;

   // Configuration registers and their per-frame copies.
   logic [WIDTH_BITS-1:0]  cfg_w_ff;
   logic [HEIGHT_BITS-1:0] cfg_h_ff;
   logic [RADIUS_BITS-1:0] cfg_r_ff;
   logic [AMOUNT_BITS-1:0] cfg_amt_ff;
   logic [THRESH_BITS-1:0] cfg_thr_ff;

   logic [WIDTH_BITS-1:0]  lat_w_ff, lat_w_in;
   logic [HEIGHT_BITS-1:0] lat_h_ff, lat_h_in;
   logic [RB-1:0]          lat_r_ff, lat_r_in;
   logic [AMOUNT_BITS-1:0] lat_amt_ff;
   logic [THRESH_BITS-1:0] lat_thr_ff;
   logic [CNT_BITS-1:0]    lag_ff;
   logic [RCB-1:0]         recip_ff, recip_in;
   logic [SB-1:0]          bias_ff;

   // Raster positions. The ring indexes follow the rows modulo RING.
   logic [CB-1:0]          in_col_ff, out_col_ff;
   logic [HEIGHT_BITS-1:0] in_row_ff, out_row_ff;
   logic [RGB-1:0]         in_ring_ff, out_ring_ff;
   logic                   in_done_ff;
   logic [CNT_BITS-1:0]    pend_ff;

   logic [PIXEL_BITS-1:0]  px_ff;
   logic signed [RB:0]     dy_ff, dx_ff;
   logic [SB-1:0]          sum_ff;
   logic [PIXEL_BITS-1:0]  p_ff;
   logic                   rd_valid_ff, rd_center_ff;
   logic signed [22:0]     prod_ff, prod_in;

   logic                   rsp_valid_ff;
   logic [PIXEL_BITS-1:0]  rsp_pixel_ff;
   logic                   rsp_last_ff;

   logic                   accept;
   logic                   mem_wr_en, mem_rd_en;
   logic [AB-1:0]          wr_addr, rd_addr, win_addr, ctr_addr;
   logic [PIXEL_BITS-1:0]  rd_data;
   logic                   div_start, div_done;
   logic [SB-1:0]          div_quo;

   logic signed [15:0]     r_c, row_idx, mrow, col_idx, mcol, ring_s, h_s, w_s;
   logic signed [9:0]      d_v, thr_s;
   logic signed [23:0]     t_v;
   logic [23:0]            q_v;
   logic [PIXEL_BITS-1:0]  q_pix;
   logic                   last_v;
   logic                   win_x_end, win_y_end;

   assign req_chan.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept         = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.pixel_out  = rsp_pixel_ff;
   assign rsp_chan.frame_last = rsp_last_ff;

   // Clamp the registers into the ranges the datapath handles.
   always_comb begin
      lat_w_in = (cfg_w_ff == '0) ? WIDTH_BITS'(1) : cfg_w_ff;
      if (32'(lat_w_in) > MAX_WIDTH) begin
         lat_w_in = WIDTH_BITS'(MAX_WIDTH);
      end
      lat_h_in = (cfg_h_ff == '0) ? HEIGHT_BITS'(1) : cfg_h_ff;
      r_c = $signed(16'(cfg_r_ff));
      if (r_c > $signed(16'(MAX_RADIUS))) begin
         r_c = $signed(16'(MAX_RADIUS));
      end
      if (r_c > $signed(16'(lat_w_in)) - 16'sd1) begin
         r_c = $signed(16'(lat_w_in)) - 16'sd1;
      end
      if (r_c > $signed(16'(lat_h_in)) - 16'sd1) begin
         r_c = $signed(16'(lat_h_in)) - 16'sd1;
      end
      lat_r_in = RB'(r_c);
   end

   // Reciprocal of the window size, rounded up, picked from a constant table
   // with one entry per radius.
   always_comb begin
      recip_in = '0;
      for (int i = 0; i <= MAX_RADIUS; i++) begin
         if (lat_r_ff == RB'(i)) begin
            recip_in = RCB'(((64'd1 << KB) + 64'((2 * i + 1) * (2 * i + 1)) - 64'd1)
                            / 64'((2 * i + 1) * (2 * i + 1)));
         end
      end
   end

   // Window address: mirror row and column, then place the row in the ring.
   always_comb begin
      h_s     = $signed(16'(lat_h_ff));
      w_s     = $signed(16'(lat_w_ff));
      row_idx = $signed(16'(out_row_ff)) + 16'(dy_ff);
      if (row_idx < 16'sd0) begin
         mrow = -row_idx;
      end else if (row_idx >= h_s) begin
         mrow = 16'sd2 * (h_s - 16'sd1) - row_idx;
      end else begin
         mrow = row_idx;
      end
      col_idx = $signed(16'(out_col_ff)) + 16'(dx_ff);
      if (col_idx < 16'sd0) begin
         mcol = -col_idx;
      end else if (col_idx >= w_s) begin
         mcol = 16'sd2 * (w_s - 16'sd1) - col_idx;
      end else begin
         mcol = col_idx;
      end
      // The mirrored row lies within 2R of the output row, so one fix suffices.
      ring_s = $signed(16'(out_ring_ff)) + mrow - $signed(16'(out_row_ff));
      if (ring_s < 16'sd0) begin
         ring_s = ring_s + $signed(16'(RING));
      end else if (ring_s >= $signed(16'(RING))) begin
         ring_s = ring_s - $signed(16'(RING));
      end
      win_addr = AB'(ring_s) * AB'(MAX_WIDTH) + AB'(mcol);
      ctr_addr = AB'(out_ring_ff) * AB'(MAX_WIDTH) + AB'(out_col_ff);
      wr_addr  = AB'(in_ring_ff) * AB'(MAX_WIDTH) + AB'(in_col_ff);
   end

   assign mem_wr_en = (state_ff == S_PIX);
   assign mem_rd_en = (state_ff == S_WIN) || (state_ff == S_CTR);
   assign rd_addr   = (state_ff == S_CTR) ? ctr_addr : win_addr;
   assign win_x_end = (dx_ff == $signed({1'b0, lat_r_ff}));
   assign win_y_end = (dy_ff == $signed({1'b0, lat_r_ff}));
   assign div_start = (state_ff == S_DSET);

   // Difference, coring and gain; then rounding and clamping.
   always_comb begin
      d_v   = $signed({2'b00, p_ff}) - $signed({2'b00, div_quo[PIXEL_BITS-1:0]});
      thr_s = $signed({2'b00, lat_thr_ff});
      if (d_v < thr_s && d_v > -thr_s) begin
         d_v = 10'sd0;
      end
      prod_in = 23'(d_v) * $signed(23'(lat_amt_ff));
      t_v     = $signed(24'({p_ff, 8'h00})) + 24'(prod_ff);
      q_v     = 24'(t_v + 24'sd128) >> 8;
      if (t_v < 24'sd0) begin
         q_pix = '0;
      end else if (q_v > 24'(PIX_MAX)) begin
         q_pix = PIX_MAX;
      end else begin
         q_pix = q_v[PIXEL_BITS-1:0];
      end
      last_v = (out_row_ff == lat_h_ff - HEIGHT_BITS'(1)) &&
               (14'(out_col_ff) == 14'(lat_w_ff) - 14'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff   <= RST_WIDTH;
         cfg_h_ff   <= RST_HEIGHT;
         cfg_r_ff   <= RST_RADIUS;
         cfg_amt_ff <= RST_AMOUNT;
         cfg_thr_ff <= RST_THRESH;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:     cfg_w_ff   <= csr_wr_data[WIDTH_BITS-1:0];
            CSR_FRAME_HEIGHT:    cfg_h_ff   <= csr_wr_data[HEIGHT_BITS-1:0];
            CSR_BLUR_RADIUS:     cfg_r_ff   <= csr_wr_data[RADIUS_BITS-1:0];
            CSR_SHARPEN_AMOUNT:  cfg_amt_ff <= csr_wr_data[AMOUNT_BITS-1:0];
            CSR_NOISE_THRESHOLD: cfg_thr_ff <= csr_wr_data[THRESH_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_ring_ff   <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_ring_ff  <= '0;
         in_done_ff   <= 1'b0;
         pend_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lat_w_ff     <= RST_WIDTH;
         lat_h_ff     <= RST_HEIGHT;
         lat_r_ff     <= RB'(RST_RADIUS);
         lat_amt_ff   <= RST_AMOUNT;
         lat_thr_ff   <= RST_THRESH;
         lag_ff       <= CNT_BITS'(641);
         recip_ff     <= RCB'(((64'd1 << KB) + 64'd8) / 64'd9);
         bias_ff      <= SB'(4);
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         rd_valid_ff  <= mem_rd_en;
         rd_center_ff <= (state_ff == S_CTR);
         if (rd_valid_ff) begin
            if (rd_center_ff) begin
               p_ff <= rd_data;
            end else begin
               sum_ff <= sum_ff + SB'(rd_data);
            end
         end

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  px_ff <= req_chan.pixel_in;
                  if (op_type'(req_chan.operation) == OP_PIXEL && !in_done_ff) begin
                     if (in_row_ff == '0 && in_col_ff == '0) begin
                        lat_w_ff   <= lat_w_in;
                        lat_h_ff   <= lat_h_in;
                        lat_r_ff   <= lat_r_in;
                        lat_amt_ff <= cfg_amt_ff;
                        lat_thr_ff <= cfg_thr_ff;
                        state_ff   <= S_LAG;
                     end else begin
                        state_ff <= S_PIX;
                     end
                  end else if (in_done_ff) begin
                     // Drain, or a pixel arriving while the tail is pending.
                     dy_ff    <= -$signed({1'b0, lat_r_ff});
                     dx_ff    <= -$signed({1'b0, lat_r_ff});
                     sum_ff   <= '0;
                     state_ff <= S_WIN;
                  end
               end
            end
            S_LAG: begin
               lag_ff   <= CNT_BITS'(lat_r_ff) * CNT_BITS'(lat_w_ff) + CNT_BITS'(lat_r_ff);
               recip_ff <= recip_in;
               bias_ff  <= SB'({lat_r_ff, 1'b0} * (SB'(lat_r_ff) + SB'(1)));
               state_ff <= S_PIX;
            end
            S_PIX: begin
               if (14'(in_col_ff) + 14'd1 >= 14'(lat_w_ff)) begin
                  in_col_ff <= '0;
                  if (in_row_ff + HEIGHT_BITS'(1) >= lat_h_ff) begin
                     in_row_ff  <= '0;
                     in_ring_ff <= '0;
                     in_done_ff <= 1'b1;
                  end else begin
                     in_row_ff  <= in_row_ff + HEIGHT_BITS'(1);
                     in_ring_ff <= (in_ring_ff == RGB'(RING - 1)) ? '0
                                   : in_ring_ff + RGB'(1);
                  end
               end else begin
                  in_col_ff <= in_col_ff + CB'(1);
               end
               pend_ff <= pend_ff + CNT_BITS'(1);
               if (pend_ff + CNT_BITS'(1) > lag_ff) begin
                  dy_ff    <= -$signed({1'b0, lat_r_ff});
                  dx_ff    <= -$signed({1'b0, lat_r_ff});
                  sum_ff   <= '0;
                  state_ff <= S_WIN;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_WIN: begin
               if (win_x_end) begin
                  dx_ff <= -$signed({1'b0, lat_r_ff});
                  if (win_y_end) begin
                     state_ff <= S_CTR;
                  end else begin
                     dy_ff <= dy_ff + (RB+1)'(1);
                  end
               end else begin
                  dx_ff <= dx_ff + (RB+1)'(1);
               end
            end
            S_CTR:  state_ff <= S_RDW;
            S_RDW:  state_ff <= S_DSET;
            S_DSET: state_ff <= S_DIV;
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= S_RND;
            end
            S_RND: begin
               rsp_valid_ff <= 1'b1;
               rsp_pixel_ff <= q_pix;
               rsp_last_ff  <= last_v;
               if (last_v) begin
                  in_col_ff   <= '0;
                  in_row_ff   <= '0;
                  in_ring_ff  <= '0;
                  out_col_ff  <= '0;
                  out_row_ff  <= '0;
                  out_ring_ff <= '0;
                  in_done_ff  <= 1'b0;
                  pend_ff     <= '0;
               end else begin
                  pend_ff <= pend_ff - CNT_BITS'(1);
                  if (14'(out_col_ff) + 14'd1 >= 14'(lat_w_ff)) begin
                     out_col_ff  <= '0;
                     out_row_ff  <= out_row_ff + HEIGHT_BITS'(1);
                     out_ring_ff <= (out_ring_ff == RGB'(RING - 1)) ? '0
                                    : out_ring_ff + RGB'(1);
                  end else begin
                     out_col_ff <= out_col_ff + CB'(1);
                  end
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   bbum_line_store #(
      .DEPTH (DEPTH),
      .AB    (AB)
   ) u_store (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (px_ff),
      .rd_en      (mem_rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   bbum_divider #(
      .NUM_BITS (SB),
      .REC_BITS (RCB),
      .SHIFT    (KB)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (sum_ff + bias_ff),
      .recip   (recip_ff),
      .done_ff (div_done),
      .quo_ff  (div_quo)
   );

endmodule

`default_nettype wire
